[rtl/core/icv_pkg.sv]
// Shared types and constants for the 2D convolution (correlation) block.
// Used by every module under rtl/core except icv_ram; depends on nothing else.
package icv_pkg;

   localparam int KERNEL_SIZE  = 3;
   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 4096;
   localparam int TAPS         = KERNEL_SIZE * KERNEL_SIZE;
   localparam int HALF         = KERNEL_SIZE / 2;

   localparam int SAMPLE_W     = 16;
   localparam int COEF_W       = 16;
   localparam int IDX_W        = 6;
   localparam int TAP_IDX_W    = $clog2(TAPS);
   localparam int COL_W        = 10;
   localparam int ROW_W        = 12;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_IDX_W    = 1;
   localparam int VALUE_W      = 38;
   localparam int PROD_W       = SAMPLE_W + COEF_W;
   localparam int PART_W       = PROD_W + $clog2(KERNEL_SIZE);
   localparam int SUM_W        = PROD_W + $clog2(TAPS);
   localparam int LINE_W       = SAMPLE_W * (KERNEL_SIZE - 1);
   localparam int LINE_ADDR_W  = $clog2(MAX_WIDTH);

   localparam int REQ_FIELDS_W = SAMPLE_W + IDX_W + COEF_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = COL_W + ROW_W + VALUE_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_COEF  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef sample_type [TAPS-1:0] window_type;

   typedef struct packed {
      logic                kind;
      logic [SAMPLE_W-1:0] sample;
      logic [IDX_W-1:0]    coef_index;
      logic [COEF_W-1:0]   coef_value;
   } req_item_type;

   typedef struct packed {
      logic [COL_W-1:0] x;
      logic [ROW_W-1:0] y;
      logic             last;
   } meta_type;

   typedef struct packed {
      logic       valid;
      window_type window;
      meta_type   meta;
   } win_stage_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  index;
      logic [COEF_W-1:0] value;
   } coef_wr_type;

   typedef struct packed {
      meta_type           meta;
      logic [VALUE_W-1:0] value;
   } rsp_item_type;

endpackage

[rtl/core/icv_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; the read returns the old contents when it hits the address being written.
module icv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/icv_front.sv]
// Input register, raster position counters, line buffer and sample window.
// Depends on icv_pkg and icv_ram.
module icv_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  icv_pkg::req_item_type               in_item,
   input  logic [icv_pkg::WIDTH_REG_W-1:0]     width,
   input  logic [icv_pkg::HEIGHT_REG_W-1:0]    height,
   input  logic                                restart,
   input  logic                                out_ready,
   output icv_pkg::win_stage_type              out_stage,
   output icv_pkg::coef_wr_type                coef_wr
);
   import icv_pkg::*;

   typedef struct packed {
      logic              kind;
      sample_type        sample;
      logic [IDX_W-1:0]  coef_index;
      logic [COEF_W-1:0] coef_value;
      logic [COL_W-1:0]  col;
      logic              emit;
      meta_type          meta;
   } s0_type;

   logic             s0_valid_ff, s0_valid_in;
   s0_type           s0_ff, s0_in;
   logic             s1_valid_ff, s1_valid_in;
   meta_type         meta1_ff, meta1_in;
   window_type       window_ff, window_in, window_shift;
   logic [COL_W-1:0] col_count_ff, col_count_in;
   logic [ROW_W-1:0] row_count_ff, row_count_in;

   logic              accept, take0, pixel0, col_last, row_last;
   logic [LINE_W-1:0] line_rd_data, line_wr_data;
   sample_type [KERNEL_SIZE-1:0] col_vec;

   assign pixel0   = (s0_ff.kind == KIND_PIXEL);
   assign take0    = s0_valid_ff && (!s1_valid_ff || out_ready);
   assign in_ready = !s0_valid_ff || take0;
   assign accept   = in_valid && in_ready;

   assign col_last = (WIDTH_REG_W'(col_count_ff) + WIDTH_REG_W'(1)) == width;
   assign row_last = (HEIGHT_REG_W'(row_count_ff) + HEIGHT_REG_W'(1)) == height;

   always_comb begin
      s0_in            = s0_ff;
      s0_in.kind       = in_item.kind;
      s0_in.sample     = in_item.sample;
      s0_in.coef_index = in_item.coef_index;
      s0_in.coef_value = in_item.coef_value;
      s0_in.col        = col_count_ff;
      s0_in.emit       = (col_count_ff >= COL_W'(KERNEL_SIZE - 1))
                         && (row_count_ff >= ROW_W'(KERNEL_SIZE - 1));
      s0_in.meta.x     = col_count_ff - COL_W'(HALF);
      s0_in.meta.y     = row_count_ff - ROW_W'(HALF);
      s0_in.meta.last  = col_last && row_last;
   end

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      priority if (restart) begin
         col_count_in = '0;
         row_count_in = '0;
      end else if (accept && (in_item.kind == KIND_PIXEL)) begin
         if (col_last) begin
            col_count_in = '0;
            row_count_in = row_last ? '0 : row_count_ff + ROW_W'(1);
         end else begin
            col_count_in = col_count_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      s0_valid_in = s0_valid_ff;
      priority if (accept) begin
         s0_valid_in = 1'b1;
      end else if (take0) begin
         s0_valid_in = 1'b0;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      priority if (take0) begin
         s1_valid_in = pixel0 && s0_ff.emit;
      end else if (out_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   // Column entering the window: the rows above from the line buffer, this row's sample last.
   always_comb begin
      for (int r = 0; r < KERNEL_SIZE - 1; r++) begin
         col_vec[r] = line_rd_data[r*SAMPLE_W +: SAMPLE_W];
      end
      col_vec[KERNEL_SIZE-1] = s0_ff.sample;
      for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
         line_wr_data[j*SAMPLE_W +: SAMPLE_W] = col_vec[j+1];
      end
   end

   always_comb begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         for (int c = 0; c < KERNEL_SIZE; c++) begin
            if (c < KERNEL_SIZE - 1) begin
               window_shift[r*KERNEL_SIZE+c] = window_ff[r*KERNEL_SIZE+c+1];
            end else begin
               window_shift[r*KERNEL_SIZE+c] = col_vec[r];
            end
         end
      end
   end

   assign window_in = (take0 && pixel0) ? window_shift : window_ff;
   assign meta1_in  = take0 ? s0_ff.meta : meta1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_ff <= s0_in;
      end
      window_ff <= window_in;
      meta1_ff  <= meta1_in;
   end

   icv_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (take0 && pixel0),
      .wr_addr (s0_ff.col[LINE_ADDR_W-1:0]),
      .wr_data (line_wr_data),
      .rd_en   (accept),
      .rd_addr (col_count_ff[LINE_ADDR_W-1:0]),
      .rd_data (line_rd_data)
   );

   assign out_stage.valid  = s1_valid_ff;
   assign out_stage.window = window_ff;
   assign out_stage.meta   = meta1_ff;

   assign coef_wr.en    = take0 && (s0_ff.kind == KIND_COEF);
   assign coef_wr.index = s0_ff.coef_index;
   assign coef_wr.value = s0_ff.coef_value;

endmodule

[rtl/core/icv_mac.sv]
// Coefficient table, tap multipliers, two-level adder tree and result register.
// Depends on icv_pkg.
module icv_mac (
   input  logic                   clock,
   input  logic                   reset,
   input  icv_pkg::win_stage_type in_stage,
   output logic                   in_ready,
   input  icv_pkg::coef_wr_type   coef_wr,
   output logic                   out_valid,
   input  logic                   out_ready,
   output icv_pkg::rsp_item_type  out_item
);
   import icv_pkg::*;

   logic signed [COEF_W-1:0] coef_ff [TAPS];
   logic signed [PROD_W-1:0] prod_ff [TAPS];
   logic signed [PART_W-1:0] part_ff [KERNEL_SIZE];
   logic signed [PART_W-1:0] part_in [KERNEL_SIZE];
   logic signed [VALUE_W-1:0] value_in;
   meta_type                 meta2_ff, meta3_ff;
   rsp_item_type             rsp_ff;
   logic                     v2_ff, v3_ff, v4_ff;
   logic                     free2, free3, free4;

   assign free4    = !v4_ff || out_ready;
   assign free3    = !v3_ff || free4;
   assign free2    = !v2_ff || free3;
   assign in_ready = free2;

   always_comb begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         part_in[r] = '0;
         for (int c = 0; c < KERNEL_SIZE; c++) begin
            part_in[r] = part_in[r] + PART_W'(prod_ff[r*KERNEL_SIZE+c]);
         end
      end
   end

   always_comb begin
      value_in = '0;
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         value_in = value_in + VALUE_W'(part_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         for (int i = 0; i < TAPS; i++) begin
            coef_ff[i] <= '0;
         end
      end else begin
         if (free2) begin
            v2_ff <= in_stage.valid;
         end
         if (free3) begin
            v3_ff <= v2_ff;
         end
         if (free4) begin
            v4_ff <= v3_ff;
         end
         if (coef_wr.en && (coef_wr.index < IDX_W'(TAPS))) begin
            coef_ff[coef_wr.index[TAP_IDX_W-1:0]] <= coef_wr.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (free2) begin
         for (int i = 0; i < TAPS; i++) begin
            prod_ff[i] <= $signed(in_stage.window[i]) * coef_ff[i];
         end
         meta2_ff <= in_stage.meta;
      end
      if (free3) begin
         for (int r = 0; r < KERNEL_SIZE; r++) begin
            part_ff[r] <= part_in[r];
         end
         meta3_ff <= meta2_ff;
      end
      if (free4) begin
         rsp_ff.meta  <= meta3_ff;
         rsp_ff.value <= value_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_item  = rsp_ff;

endmodule

[rtl/core/image_conv2d_valid.sv]
// Top level of the streaming 2D sliding-window correlation with valid-only output.
// Depends on icv_pkg, icv_front, icv_mac and icv_ram.
//
// Channel  Dir  Handshake                Payload
// req      in   req_tvalid / req_tready  tdata: sample, coef_index, coef_value; tuser: kind
// rsp      out  rsp_tvalid / rsp_tready  tdata: out_x, out_y, value; tlast: last
// csr      in   csr_we                   csr_index, csr_wdata
//
// One request is taken per clock while no held result stalls the pipeline.
// The rate is set by the single-port-per-direction line buffer, read once and written once
// per pixel, and by the five-stage register chain from input register to result register.
// Reset clears control state and the coefficients; line buffer contents are never used for
// a result before being written in the same frame, so no clearing pass runs.
// A stalled result holds every stage behind it; empty stages still fill meanwhile.
module image_conv2d_valid (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [15:0] sample, [21:16] coef_index, [37:22] coef_value, rest zero
   input  logic [icv_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [0] kind
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [9:0] out_x, [21:10] out_y, [59:22] value, rest zero
   output logic [icv_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [icv_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [icv_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import icv_pkg::*;

   logic [WIDTH_REG_W-1:0]  width_ff, width_in, width_raw;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in, height_raw;
   req_item_type            req_item;
   win_stage_type           win_stage;
   coef_wr_type             coef_wr;
   rsp_item_type            rsp_item;
   logic                    mac_ready;
   logic [COL_W-1:0]        last_x;
   logic [ROW_W-1:0]        last_y;

   assign width_raw  = csr_wdata[WIDTH_REG_W-1:0];
   assign height_raw = csr_wdata[HEIGHT_REG_W-1:0];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH: begin
               priority if (width_raw == '0) begin
                  width_in = WIDTH_REG_W'(1);
               end else if (width_raw > WIDTH_REG_W'(MAX_WIDTH)) begin
                  width_in = WIDTH_REG_W'(MAX_WIDTH);
               end else begin
                  width_in = width_raw;
               end
            end
            REG_IMAGE_HEIGHT: begin
               priority if (height_raw == '0) begin
                  height_in = HEIGHT_REG_W'(1);
               end else if (height_raw > HEIGHT_REG_W'(MAX_HEIGHT)) begin
                  height_in = HEIGHT_REG_W'(MAX_HEIGHT);
               end else begin
                  height_in = height_raw;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_REG_W'(100);
         height_ff <= HEIGHT_REG_W'(100);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign req_item.kind       = req_tuser;
   assign req_item.sample     = req_tdata[SAMPLE_W-1:0];
   assign req_item.coef_index = req_tdata[SAMPLE_W +: IDX_W];
   assign req_item.coef_value = req_tdata[SAMPLE_W+IDX_W +: COEF_W];

   icv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .width     (width_ff),
      .height    (height_ff),
      .restart   (csr_we),
      .out_ready (mac_ready),
      .out_stage (win_stage),
      .coef_wr   (coef_wr)
   );

   icv_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (win_stage),
      .in_ready  (mac_ready),
      .coef_wr   (coef_wr),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

   assign rsp_tdata = {(RSP_TDATA_W - RSP_FIELDS_W)'(0), rsp_item.value,
                       rsp_item.meta.y, rsp_item.meta.x};
   assign rsp_tlast = rsp_item.meta.last;

   assign last_x = COL_W'(width_ff - WIDTH_REG_W'(1 + HALF));
   assign last_y = ROW_W'(height_ff - HEIGHT_REG_W'(1 + HALF));

   // The pipeline only backs up into the request side when a result is held.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("request side stalled without a held result");

   // The frame's final result sits at the bottom-right interior centre.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> ((rsp_item.meta.x == last_x) && (rsp_item.meta.y == last_y)))
      else $error("last flag on a result away from the final interior centre");

   // The exact sum never needs the top bits of the result field.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((&rsp_item.value[VALUE_W-1:SUM_W-1])
                      || !(|rsp_item.value[VALUE_W-1:SUM_W-1])))
      else $error("sum of products outside its exact range");

endmodule
